>>> rtl/kkbr_pkg.sv
// ----------------------------------------------------------------------------
// kkbr_pkg
// Shared types and constants for the keypad key bitmap reporter.
// ----------------------------------------------------------------------------
package kkbr_pkg;

  localparam int COUNT_W    = 7;   // key_count and internal key counters
  localparam int SLOT_W     = 6;
  localparam int CODE_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int BYTE_NUM_W = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MAX_TABLE  = 64;  // bitmap never exceeds 64 keys

  localparam logic [BYTE_NUM_W-1:0] BYTE_NUM_MASK = 3'h7;

  // Register index, taken from paddr[2].
  localparam logic REG_KEY_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_KEY     = 2'd1,
    OP_POLL    = 2'd2,
    OP_FETCHED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot_index;
    logic [CODE_W-1:0] key_code;
    logic              pressed;
    logic              send_accepted;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]     report_byte;
    logic [BYTE_NUM_W-1:0] byte_number;
    logic                  last_byte;
  } rpt_t;

endpackage

>>> rtl/kkbr_ram.sv
// ----------------------------------------------------------------------------
// kkbr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kkbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/kkbr_ctrl.sv
// ----------------------------------------------------------------------------
// kkbr_ctrl
// Sequencer: walks the key table through one shared comparator, keeps the
// report bitmap and flags, and shifts the report out one byte per cycle while rpt_stall is low.
// ----------------------------------------------------------------------------
module kkbr_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [kkbr_pkg::COUNT_W-1:0]      n,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  kkbr_pkg::req_t                    req,
  output logic                              rpt_valid,
  input  logic                              rpt_stall,
  output kkbr_pkg::rpt_t                    rpt,
  output logic                              ram_we,
  output logic [$clog2(DEPTH)-1:0]          ram_waddr,
  output logic [kkbr_pkg::CODE_W-1:0]       ram_wdata,
  output logic [$clog2(DEPTH)-1:0]          ram_raddr,
  input  logic [kkbr_pkg::CODE_W-1:0]       ram_rdata
);

  localparam int AW     = $clog2(DEPTH);
  localparam int SNAP_W = ((DEPTH + 7) / 8) * 8;

  kkbr_pkg::state_t state, state_next;

  logic                             req_accept;
  logic                             rpt_load;
  logic                             issue_ok;
  logic                             hit;
  logic                             poll_ok;
  logic                             last;
  logic [kkbr_pkg::BYTE_W-1:0]      byte_val;

  logic [kkbr_pkg::COUNT_W-1:0]     idx;
  logic                             cmp_valid;
  logic [AW-1:0]                    cmp_idx;
  logic [kkbr_pkg::CODE_W-1:0]      code_q;
  logic                             pressed_q;
  logic                             accepted_q;
  logic [DEPTH-1:0]                 key_bits;
  logic                             report_dirty;
  logic                             host_ready;
  logic [SNAP_W-1:0]                snap;
  logic [kkbr_pkg::COUNT_W-1:0]     rem;
  logic [kkbr_pkg::BYTE_NUM_W-1:0]  byte_cnt;

  assign req_stall  = (state != kkbr_pkg::ST_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign rpt_load   = (state == kkbr_pkg::ST_EMIT) && (!rpt_valid || !rpt_stall);
  assign issue_ok   = (state == kkbr_pkg::ST_SEARCH) && (idx < n);
  assign hit        = cmp_valid && (ram_rdata == code_q);
  assign poll_ok    = host_ready && report_dirty;
  assign last       = (rem <= kkbr_pkg::COUNT_W'(kkbr_pkg::BYTE_W));

  assign ram_we    = req_accept && (req.op == kkbr_pkg::OP_LOAD)
                     && ({1'b0, req.slot_index} < kkbr_pkg::COUNT_W'(DEPTH));
  assign ram_waddr = req.slot_index[AW-1:0];
  assign ram_wdata = req.key_code;
  assign ram_raddr = idx[AW-1:0];

  // Bits at or above the key count are sent as zero.
  always_comb begin
    for (int j = 0; j < kkbr_pkg::BYTE_W; j++) begin
      byte_val[j] = snap[j] && (kkbr_pkg::COUNT_W'(j) < rem);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kkbr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      kkbr_pkg::ST_IDLE: begin
        if (req_accept) begin
          if (req.op == kkbr_pkg::OP_KEY) begin
            state_next = kkbr_pkg::ST_SEARCH;
          end else if (req.op == kkbr_pkg::OP_POLL && poll_ok && n != '0) begin
            state_next = kkbr_pkg::ST_EMIT;
          end
        end
      end
      kkbr_pkg::ST_SEARCH: begin
        if (hit || (!issue_ok && !cmp_valid)) begin
          state_next = kkbr_pkg::ST_IDLE;
        end
      end
      kkbr_pkg::ST_EMIT: begin
        if (rpt_load && last) begin
          state_next = kkbr_pkg::ST_IDLE;
        end
      end
      default: state_next = kkbr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      host_ready   <= 1'b0;
      report_dirty <= 1'b1;
      key_bits     <= '0;
      cmp_valid    <= 1'b0;
      rpt_valid    <= 1'b0;
    end else begin
      if (req_accept) begin
        code_q     <= req.key_code;
        pressed_q  <= req.pressed;
        accepted_q <= req.send_accepted;
        idx        <= '0;
        snap       <= SNAP_W'(key_bits);
        rem        <= n;
        byte_cnt   <= '0;
        if (req.op == kkbr_pkg::OP_FETCHED) begin
          host_ready <= 1'b1;
        end
        // An empty report emits nothing; only the dirty flag follows the host.
        if (req.op == kkbr_pkg::OP_POLL && poll_ok && n == '0) begin
          report_dirty <= !req.send_accepted;
        end
      end

      if (state == kkbr_pkg::ST_SEARCH) begin
        idx       <= idx + kkbr_pkg::COUNT_W'(issue_ok);
        cmp_valid <= issue_ok && !hit;
        cmp_idx   <= idx[AW-1:0];
        if (hit) begin
          key_bits[cmp_idx] <= pressed_q;
          report_dirty      <= 1'b1;
        end
      end else begin
        cmp_valid <= 1'b0;
      end

      if (rpt_load) begin
        rpt.report_byte <= byte_val;
        rpt.byte_number <= byte_cnt & kkbr_pkg::BYTE_NUM_MASK;
        rpt.last_byte   <= last;
        rpt_valid       <= 1'b1;
        snap            <= snap >> kkbr_pkg::BYTE_W;
        rem             <= rem - kkbr_pkg::COUNT_W'(kkbr_pkg::BYTE_W);
        byte_cnt        <= byte_cnt + 1'b1;
        if (last) begin
          report_dirty <= !accepted_q;
        end
      end else if (rpt_valid && !rpt_stall) begin
        rpt_valid <= 1'b0;
      end
    end
  end

  // A compare in flight always refers to an entry in use.
  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (kkbr_pkg::COUNT_W'(cmp_idx) < n))
    else $error("compare issued beyond the keys in use");

  // A table match always leaves the report marked dirty.
  a_hit_dirty: assert property (@(posedge clk) disable iff (rst)
    (state == kkbr_pkg::ST_SEARCH && hit) |=> report_dirty)
    else $error("report not dirty after a key match");

  // Byte emission only runs while report bits remain.
  a_emit_rem: assert property (@(posedge clk) disable iff (rst)
    (state == kkbr_pkg::ST_EMIT) |-> (rem != '0))
    else $error("emitting with no report bits left");

  // Once the descriptor is fetched the host stays ready.
  a_host_sticky: assert property (@(posedge clk) disable iff (rst)
    host_ready |=> host_ready)
    else $error("host ready flag dropped");

endmodule

>>> rtl/keypad_key_bitmap_reporter_core.sv
// ----------------------------------------------------------------------------
// keypad_key_bitmap_reporter_core
// Keypad key table with a bitmap report, emitted byte by byte on poll.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------
//   req      | req_valid / req_stall | kkbr_pkg::req_t
//   rpt      | rpt_valid / rpt_stall | kkbr_pkg::rpt_t
//   config   | APB-style, pready = 1 | key_count at byte address 0
//
// A load, a descriptor fetch or an ineligible poll leaves the core idle.
// A key event reads the table one entry per cycle through a single
// comparator over the first n entries, n being the keys in use.
// An eligible poll sends one rpt transfer per report byte.
// Reset clears the bitmap and key_count, sets the report dirty and clears
// host ready; the key table is undefined until loaded.
// rpt_stall holds the byte sequencer; req_stall is high outside the idle state.
// ----------------------------------------------------------------------------
module keypad_key_bitmap_reporter_core #(
  parameter int MAX_KEYS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  kkbr_pkg::req_t                      req,
  output logic                                rpt_valid,
  input  logic                                rpt_stall,
  output kkbr_pkg::rpt_t                      rpt,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [kkbr_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [kkbr_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [kkbr_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int DEPTH = (MAX_KEYS < kkbr_pkg::MAX_TABLE) ? MAX_KEYS
                                                          : kkbr_pkg::MAX_TABLE;
  localparam int AW    = $clog2(DEPTH);

  logic [kkbr_pkg::COUNT_W-1:0] key_count;
  logic [kkbr_pkg::COUNT_W-1:0] n;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [kkbr_pkg::CODE_W-1:0]  ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [kkbr_pkg::CODE_W-1:0]  ram_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == kkbr_pkg::REG_KEY_COUNT) begin
      key_count <= pwdata[kkbr_pkg::COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == kkbr_pkg::REG_KEY_COUNT)
                  ? kkbr_pkg::CFG_DATA_W'(key_count) : '0;

  assign n = (key_count > kkbr_pkg::COUNT_W'(DEPTH)) ? kkbr_pkg::COUNT_W'(DEPTH)
                                                     : key_count;

  kkbr_ram #(
    .WIDTH (kkbr_pkg::CODE_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kkbr_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .n         (n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule
